// File: rtl/mgl_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Month grid layout package
// Shared types, constants and small calendar tables for the month grid block.
// ---------------------------------------------------------------------------
package mgl_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int GRID_W  = 3;

    localparam logic [YEAR_W-1:0]  YEAR_DEFAULT = 14'd2026;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR    = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;

    // Reciprocal multipliers for division by 100 and by 7.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [12:0] DIV7_MUL     = 13'd4682;
    localparam int          DIV7_SHIFT   = 15;

    typedef enum logic [1:0] {
        MODE_REDRAW = 2'd0,
        MODE_PREV   = 2'd1,
        MODE_NEXT   = 2'd2,
        MODE_TODAY  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SUM,
        B_MOD,
        B_EMIT
    } t_back_state;

    // One month to lay out; today_day is zero when today is not in this month.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   today_day;
    } t_job;

    // Front-to-queue push request.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Queue status seen by the back end.
    typedef struct packed {
        logic empty;
        t_job job;
    } t_head;

    // floor(13 * (m + 1) / 5) for the shifted month 3..14.
    function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        unique case (m)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd2:                       n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
            default:                    n = 5'd31;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: rtl/mgl_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Month grid front end
// Accepts navigation beats, keeps the displayed month and queues one job.
// ---------------------------------------------------------------------------
module mgl_front
    import mgl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_mode,
    input  wire logic [YEAR_W-1:0]  i_today_year,
    input  wire logic [MONTH_W-1:0] i_today_month,
    input  wire logic [DAY_W-1:0]   i_today_day,
    input  wire logic               i_full,
    output logic                    o_stall,
    output t_push                   o_push
);

    logic               r_started, n_started;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  load_year, base_year;
    logic [MONTH_W-1:0] load_month, base_month;
    logic               accept;
    t_mode              mode;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign mode    = t_mode'(i_mode);

    always_comb begin
        if (i_today_year == '0) begin
            load_year = YEAR_DEFAULT;
        end else if (i_today_year > YEAR_MAX) begin
            load_year = YEAR_MAX;
        end else begin
            load_year = i_today_year;
        end
        if (i_today_month >= MONTH_JAN && i_today_month <= MONTH_DEC) begin
            load_month = i_today_month;
        end else begin
            load_month = MONTH_JAN;
        end
    end

    always_comb begin
        base_year  = r_started ? r_year  : load_year;
        base_month = r_started ? r_month : load_month;
        n_year     = base_year;
        n_month    = base_month;
        unique case (mode)
            MODE_PREV: begin
                if (base_month > MONTH_JAN) begin
                    n_month = base_month - 4'd1;
                end else if (base_year > 14'd1) begin
                    n_month = MONTH_DEC;
                    n_year  = base_year - 14'd1;
                end
            end
            MODE_NEXT: begin
                if (base_month < MONTH_DEC) begin
                    n_month = base_month + 4'd1;
                end else if (base_year < YEAR_MAX) begin
                    n_month = MONTH_JAN;
                    n_year  = base_year + 14'd1;
                end
            end
            MODE_TODAY: begin
                n_year  = load_year;
                n_month = load_month;
            end
            MODE_REDRAW: begin
            end
        endcase
        n_started = 1'b1;
    end

    always_comb begin
        o_push.valid           = accept;
        o_push.job.year        = n_year;
        o_push.job.month       = n_month;
        o_push.job.today_day   = (n_year == i_today_year && n_month == i_today_month)
                                 ? i_today_day : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_year    <= YEAR_DEFAULT;
            r_month   <= MONTH_JAN;
        end else if (accept) begin
            r_started <= n_started;
            r_year    <= n_year;
            r_month   <= n_month;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mgl_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Month grid job queue
// Short first-in first-out buffer of layout jobs between front and back.
// ---------------------------------------------------------------------------
module mgl_queue
    import mgl_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_head      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.empty = (r_count == '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mgl_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Month grid back end
// Finds the first weekday and month length, then emits one cell per day.
// ---------------------------------------------------------------------------
module mgl_back
    import mgl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_head              i_head,
    output logic                    o_pop,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [YEAR_W-1:0]       o_shown_year,
    output logic [MONTH_W-1:0]      o_shown_month,
    output logic [DAY_W-1:0]        o_day,
    output logic [GRID_W-1:0]       o_row,
    output logic [GRID_W-1:0]       o_col,
    output logic                    o_is_today,
    output logic                    o_is_weekend,
    output logic                    o_last
);

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [YEAR_W-1:0]  r_yadj;
    logic [MONTH_W-1:0] r_madj;
    logic [26:0]        r_prod;
    logic [9:0]         r_sum;
    logic [DAY_W-1:0]   r_dim;
    logic [DAY_W-1:0]   r_day;
    logic [GRID_W-1:0]  r_row, r_col;

    logic               r_o_valid;
    logic [YEAR_W-1:0]  r_o_year;
    logic [MONTH_W-1:0] r_o_month;
    logic [DAY_W-1:0]   r_o_day;
    logic [GRID_W-1:0]  r_o_row, r_o_col;
    logic               r_o_today, r_o_weekend, r_o_last;

    logic               pop, emit, out_free, emit_last;
    logic [6:0]         cent, rem;
    logic [YEAR_W-1:0]  cent_x100;
    logic               leap;
    logic [22:0]        prod7;
    logic [6:0]         quot7;
    logic [9:0]         h_full;
    logic [GRID_W-1:0]  h, first_col;

    assign out_free  = !r_o_valid || !i_stall;
    assign emit_last = (r_day == r_dim);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_head.empty) n_state = B_DIV;
            B_DIV:   n_state = B_SUM;
            B_SUM:   n_state = B_MOD;
            B_MOD:   n_state = B_EMIT;
            B_EMIT:  if (out_free && emit_last) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (r_state)
            B_IDLE:  pop  = !i_head.empty;
            B_EMIT:  emit = out_free;
            default: begin
            end
        endcase
    end

    assign o_pop = pop;

    // Zeller terms: century and year-of-century of the shifted year.
    assign cent      = r_prod[DIV100_SHIFT+6:DIV100_SHIFT];
    assign cent_x100 = YEAR_W'(cent) * 14'd100;
    assign rem       = 7'(r_yadj - cent_x100);

    // Only February needs the leap test, and then the shifted year is one less.
    assign leap = (r_job.year[1:0] == 2'b00) && ((rem != 7'd99) || (cent[1:0] == 2'b11));

    assign prod7     = 23'(r_sum) * 23'(DIV7_MUL);
    assign quot7     = prod7[DIV7_SHIFT+6:DIV7_SHIFT];
    assign h_full    = r_sum - 10'(quot7) * 10'd7;
    assign h         = h_full[GRID_W-1:0];
    assign first_col = (h == '0) ? 3'd6 : h - 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_head.job;
            if (i_head.job.month < MONTH_MAR) begin
                r_yadj <= i_head.job.year - 14'd1;
                r_madj <= i_head.job.month + 4'd12;
            end else begin
                r_yadj <= i_head.job.year;
                r_madj <= i_head.job.month;
            end
        end
        if (r_state == B_DIV) begin
            r_prod <= 27'(r_yadj) * 27'(DIV100_MUL);
        end
        if (r_state == B_SUM) begin
            r_sum <= 10'd1 + 10'(month_term(r_madj)) + 10'(rem) + 10'(rem[6:2])
                   + 10'(cent[6:2]) + 10'(cent) * 10'd5;
            r_dim <= month_length(r_job.month, leap);
        end
        if (r_state == B_MOD) begin
            r_day <= 5'd1;
            r_row <= '0;
            r_col <= first_col;
        end
        if (emit) begin
            r_day <= r_day + 5'd1;
            if (r_col == 3'd6) begin
                r_col <= '0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end
    end

    // Output register: refilled whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_year    <= r_job.year;
            r_o_month   <= r_job.month;
            r_o_day     <= r_day;
            r_o_row     <= r_row;
            r_o_col     <= r_col;
            r_o_today   <= (r_day == r_job.today_day);
            r_o_weekend <= (r_col == 3'd0) || (r_col == 3'd6);
            r_o_last    <= emit_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_shown_year  = r_o_year;
    assign o_shown_month = r_o_month;
    assign o_day         = r_o_day;
    assign o_row         = r_o_row;
    assign o_col         = r_o_col;
    assign o_is_today    = r_o_today;
    assign o_is_weekend  = r_o_weekend;
    assign o_last        = r_o_last;

endmodule
`default_nettype wire

// File: rtl/month_grid_layout_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Month grid layout
// Keeps a displayed month and lays out its days on a seven-column grid.
// ---------------------------------------------------------------------------
// Each input beat carries a navigation mode (redraw, previous month, next
// month or jump to today) together with today's date. The first beat after
// reset loads the displayed month from today's date, then applies the mode;
// a year of zero stands for 2026, a year above 9999 is held at 9999, and a
// month outside January to December is taken as January. Navigation stops at
// January of year 1 and December of year 9999. For every beat the block
// returns one output beat per day of the displayed month, 28 to 31 in day
// order, giving the day, its row and column (Sunday is column 0), a flag for
// today's date, a weekend flag and a flag on the final day. The front end
// updates the displayed month as soon as a beat is taken and places a job in
// a short queue, so input beats are taken while an earlier month is still
// being emitted. The back end takes a job from the queue, divides the year by
// 100 with a reciprocal multiplier, sums the Zeller terms and reduces modulo 7,
// each in its own state (B_IDLE, B_DIV, B_SUM, B_MOD), and then emits one day
// per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module month_grid_layout_top
    import mgl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    input  wire logic [YEAR_W-1:0]  i_today_year,
    input  wire logic [MONTH_W-1:0] i_today_month,
    input  wire logic [DAY_W-1:0]   i_today_day,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [YEAR_W-1:0]       o_shown_year,
    output logic [MONTH_W-1:0]      o_shown_month,
    output logic [DAY_W-1:0]        o_day,
    output logic [GRID_W-1:0]       o_row,
    output logic [GRID_W-1:0]       o_col,
    output logic                    o_is_today,
    output logic                    o_is_weekend,
    output logic                    o_last
);

    t_push push;
    t_head head;
    logic  queue_full;
    logic  pop;

    // Front end: owns the displayed month and decides what each beat shows.
    mgl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_today_year  (i_today_year),
        .i_today_month (i_today_month),
        .i_today_day   (i_today_day),
        .i_full        (queue_full),
        .o_stall       (o_stall),
        .o_push        (push)
    );

    // Queue decouples navigation from the slower day-by-day emission.
    mgl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    // Back end: weekday of the 1st, month length and the cell sequence.
    mgl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_shown_year  (o_shown_year),
        .o_shown_month (o_shown_month),
        .o_day         (o_day),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_is_today    (o_is_today),
        .o_is_weekend  (o_is_weekend),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// File: dv/month_grid_layout_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Month grid layout testbench
// Drives navigation beats with dates into the month grid block and checks
// every day cell that comes back against a calendar predictor of its own.
// ---------------------------------------------------------------------------
module month_grid_layout_top_test;
    import mgl_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int GAP_PERCENT   = 27;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_NS    = 2_000_000;

    // One output beat: a single day of the displayed month.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [GRID_W-1:0]  row;
        logic [GRID_W-1:0]  col;
        logic               is_today;
        logic               is_weekend;
        logic               last;
    } t_day_cell;

    // Keeps its own copy of the displayed month, lays out the expected days
    // for every accepted request and compares the returned cells in order.
    class calendar_scoreboard;
        logic [YEAR_W-1:0]  shown_year;
        logic [MONTH_W-1:0] shown_month;
        bit                 loaded;
        t_day_cell          cells_due[$];
        int                 mismatches;

        function new();
            shown_year  = YEAR_DEFAULT;
            shown_month = MONTH_JAN;
            loaded      = 1'b0;
            mismatches  = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in(int unsigned y, int unsigned m);
            case (m)
                2:           return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Zeller's congruence, turned round so that Sunday is 0.
        function int unsigned weekday_of_first(int unsigned y, int unsigned m);
            int unsigned k, c, h;
            if (m < 3) begin
                m = m + 12;
                y = y - 1;
            end
            k = y % 100;
            c = y / 100;
            h = (1 + (13 * (m + 1)) / 5 + k + k / 4 + c / 4 + 5 * c) % 7;
            return (h + 6) % 7;
        endfunction

        function void take_today(logic [YEAR_W-1:0] ty, logic [MONTH_W-1:0] tm);
            if (ty == 0)
                shown_year = YEAR_DEFAULT;
            else if (ty > YEAR_MAX)
                shown_year = YEAR_MAX;
            else
                shown_year = ty;
            shown_month = (tm >= 1 && tm <= 12) ? tm : MONTH_JAN;
        endfunction

        function void note_request(t_mode mode, logic [YEAR_W-1:0] ty,
                                   logic [MONTH_W-1:0] tm, logic [DAY_W-1:0] td);
            int unsigned first, length, marked, pos;
            t_day_cell   c;
            if (!loaded) begin
                take_today(ty, tm);
                loaded = 1'b1;
            end
            case (mode)
                MODE_PREV: begin
                    if (shown_month > MONTH_JAN) begin
                        shown_month = shown_month - 1'b1;
                    end else if (shown_year > 1) begin
                        shown_month = MONTH_DEC;
                        shown_year  = shown_year - 1'b1;
                    end
                end
                MODE_NEXT: begin
                    if (shown_month < MONTH_DEC) begin
                        shown_month = shown_month + 1'b1;
                    end else if (shown_year < YEAR_MAX) begin
                        shown_month = MONTH_JAN;
                        shown_year  = shown_year + 1'b1;
                    end
                end
                MODE_TODAY: take_today(ty, tm);
                default: ;
            endcase
            first  = weekday_of_first(shown_year, shown_month);
            length = days_in(shown_year, shown_month);
            // The raw date fields are compared, with no substitution.
            marked = (shown_year == ty && shown_month == tm) ? td : 0;
            for (int unsigned d = 1; d <= length; d++) begin
                pos          = first + d - 1;
                c.year       = shown_year;
                c.month      = shown_month;
                c.day        = DAY_W'(d);
                c.row        = GRID_W'(pos / 7);
                c.col        = GRID_W'(pos % 7);
                c.is_today   = (d == marked);
                c.is_weekend = (pos % 7 == 0) || (pos % 7 == 6);
                c.last       = (d == length);
                cells_due.push_back(c);
            end
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        endfunction

        function void check_cell(t_day_cell got);
            t_day_cell want;
            if (cells_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected day cell %0d/%0d day %0d", $time,
                             got.year, got.month, got.day);
                return;
            end
            want = cells_due.pop_front();
            if (got.year !== want.year)             report("shown_year", want.year, got.year);
            if (got.month !== want.month)           report("shown_month", want.month, got.month);
            if (got.day !== want.day)               report("day", want.day, got.day);
            if (got.row !== want.row)               report("row", want.row, got.row);
            if (got.col !== want.col)               report("col", want.col, got.col);
            if (got.is_today !== want.is_today)     report("is_today", want.is_today, got.is_today);
            if (got.is_weekend !== want.is_weekend) report("is_weekend", want.is_weekend,
                                                           got.is_weekend);
            if (got.last !== want.last)             report("last", want.last, got.last);
        endfunction

        function int pending();
            return cells_due.size();
        endfunction
    endclass

    // Clock, reset and the block's inputs, all known from time zero.
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic [1:0]          i_mode        = MODE_REDRAW;
    logic [YEAR_W-1:0]   i_today_year  = '0;
    logic [MONTH_W-1:0]  i_today_month = '0;
    logic [DAY_W-1:0]    i_today_day   = '0;
    logic                i_stall       = 1'b0;

    logic                o_stall;
    logic                o_valid;
    logic [YEAR_W-1:0]   o_shown_year;
    logic [MONTH_W-1:0]  o_shown_month;
    logic [DAY_W-1:0]    o_day;
    logic [GRID_W-1:0]   o_row;
    logic [GRID_W-1:0]   o_col;
    logic                o_is_today;
    logic                o_is_weekend;
    logic                o_last;

    // Flags shared by the sending and receiving processes.
    bit tx_gaps_on   = 1'b1;
    bit rx_gaps_on   = 1'b1;
    bit hold_request = 1'b0;

    calendar_scoreboard sb;

    month_grid_layout_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_today_year  (i_today_year),
        .i_today_month (i_today_month),
        .i_today_day   (i_today_day),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_shown_year  (o_shown_year),
        .o_shown_month (o_shown_month),
        .o_day         (o_day),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_is_today    (o_is_today),
        .o_is_weekend  (o_is_weekend),
        .o_last        (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Both channels are sampled at the rising edge, where the values seen are
    // those from before the edge, since everything else is updated with
    // nonblocking assignments. The request is noted before the cell is
    // checked, although a cell at this edge can only belong to an earlier beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_request(t_mode'(i_mode), i_today_year, i_today_month, i_today_day);
            if (o_valid && !i_stall)
                sb.check_cell(t_day_cell'{o_shown_year, o_shown_month, o_day, o_row, o_col,
                                          o_is_today, o_is_weekend, o_last});
        end
    end

    // Receiving side. Each edge gives exactly one assignment to the stall, so
    // the long hold-off and the random stalls never collide within a step.
    // The hold-off is counted here in cycles, whatever the sender is doing.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_stall      <= 1'b1;
            end else begin
                i_stall <= rx_gaps_on && ($urandom_range(0, 99) < GAP_PERCENT);
            end
        end
    end

    // Offers one request beat, after an optional random gap, and returns at
    // the edge where it is taken. Valid is only lowered when a gap follows,
    // so a back-to-back beat keeps it high with no glitch.
    task automatic send_request(t_mode mode, logic [YEAR_W-1:0] ty,
                                logic [MONTH_W-1:0] tm, logic [DAY_W-1:0] td);
        if (tx_gaps_on) begin
            while ($urandom_range(0, 99) < GAP_PERCENT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_today_year  <= ty;
        i_today_month <= tm;
        i_today_day   <= td;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // A random date, biased towards the ends of the year range, the year
    // substitutions and dates near the present. Years beyond 9999 reach the
    // top bit of the field; a few months fall outside January to December.
    task automatic send_random_request();
        logic [YEAR_W-1:0]  ty;
        logic [MONTH_W-1:0] tm;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            ty = '0;
        else if (pick < 12)
            ty = YEAR_W'($urandom_range(1, 3));
        else if (pick < 18)
            ty = YEAR_W'($urandom_range(9997, 9999));
        else if (pick < 26)
            ty = YEAR_W'($urandom_range(10000, 16383));
        else if (pick < 50)
            ty = YEAR_W'($urandom_range(1995, 2035));
        else
            ty = YEAR_W'($urandom_range(1, 9999));
        if ($urandom_range(0, 99) < 85) begin
            tm = MONTH_W'($urandom_range(1, 12));
        end else begin
            pick = $urandom_range(0, 3);
            tm   = (pick == 0) ? 4'd0 : MONTH_W'(12 + pick);
        end
        send_request(t_mode'($urandom_range(0, 3)), ty, tm, DAY_W'($urandom_range(0, 31)));
    endtask

    // Jumps to a month near one end of the calendar and walks towards that
    // end, so that navigation regularly runs into the limits.
    task automatic send_edge_walk();
        logic [YEAR_W-1:0]  ty;
        logic [MONTH_W-1:0] tm;
        logic [DAY_W-1:0]   td;
        bit                 upwards;
        upwards = $urandom_range(0, 1);
        td      = DAY_W'($urandom_range(0, 31));
        if (upwards) begin
            ty = ($urandom_range(0, 1) != 0) ? YEAR_MAX : YEAR_W'($urandom_range(10000, 16383));
            tm = MONTH_W'($urandom_range(11, 12));
        end else begin
            ty = 14'd1;
            tm = MONTH_W'($urandom_range(1, 2));
        end
        send_request(MODE_TODAY, ty, tm, td);
        repeat (3)
            send_request(upwards ? MODE_NEXT : MODE_PREV, ty, tm, td);
    endtask

    task automatic run_random(int beats);
        int sent;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 99) < 10) begin
                send_edge_walk();
                sent = sent + 4;
            end else begin
                send_random_request();
                sent = sent + 1;
            end
        end
    endtask

    // Stops offering beats until every expected cell has come back. The first
    // edge lets the monitor note the beat that was taken at this one.
    task automatic wait_for_all_cells();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats. The first beat after reset loads the displayed month
        // from an unknown year and an out-of-range month, then moves on.
        send_request(MODE_NEXT,   14'd0,     4'd15, 5'd5);
        send_request(MODE_REDRAW, 14'd2026,  4'd2,  5'd28);
        // January of year 1, then an attempt to go before it.
        send_request(MODE_TODAY,  14'd1,     4'd1,  5'd1);
        send_request(MODE_PREV,   14'd1,     4'd1,  5'd31);
        send_request(MODE_NEXT,   14'd1,     4'd0,  5'd0);
        send_request(MODE_PREV,   14'd0,     4'd1,  5'd0);
        // A year above the range is held at 9999; next month stays put there.
        send_request(MODE_TODAY,  14'd16383, 4'd12, 5'd31);
        send_request(MODE_NEXT,   14'd9999,  4'd12, 5'd31);
        send_request(MODE_PREV,   14'd10000, 4'd7,  5'd3);
        // February in century and ordinary leap years, and in common years.
        send_request(MODE_TODAY,  14'd2000,  4'd2,  5'd29);
        send_request(MODE_TODAY,  14'd1900,  4'd2,  5'd29);
        send_request(MODE_TODAY,  14'd2024,  4'd2,  5'd29);
        send_request(MODE_TODAY,  14'd2023,  4'd2,  5'd0);
        // Crossing the year boundary in both directions.
        send_request(MODE_TODAY,  14'd2026,  4'd1,  5'd15);
        send_request(MODE_PREV,   14'd2026,  4'd1,  5'd15);
        send_request(MODE_NEXT,   14'd2026,  4'd1,  5'd15);
        // Out-of-range months, and a today's day beyond a 30-day month.
        send_request(MODE_TODAY,  14'd2026,  4'd0,  5'd9);
        send_request(MODE_TODAY,  14'd2026,  4'd13, 5'd9);
        send_request(MODE_TODAY,  14'd2026,  4'd4,  5'd31);
        // Alternating bit patterns, and a run of ones, in the date fields.
        send_request(MODE_TODAY,  14'd8191,  4'd9,  5'd30);
        send_request(MODE_REDRAW, 14'd5461,  4'd10, 5'd21);
        send_request(MODE_TODAY,  14'd10922, 4'd5,  5'd10);
        send_request(MODE_NEXT,   14'd2026,  4'd15, 5'd31);

        run_random(100);

        // The receiver holds off for a long stretch while the sender keeps
        // offering beats with no gaps, so the queue fills and input stalls.
        hold_request = 1'b1;
        tx_gaps_on   = 1'b0;
        run_random(20);
        tx_gaps_on   = 1'b1;

        // The sender pauses until the block has drained completely.
        wait_for_all_cells();

        // A long stretch with no idling on either side.
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(50);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        run_random(115);

        wait_for_all_cells();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("month_grid_layout_top_test: clean");
        else
            $display("month_grid_layout_top_test: errors");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("month_grid_layout_top_test: errors");
        $finish;
    end

endmodule
